@@ rtl/grce_pkg.sv @@
// Shared types, constants and helper functions of the grid ray clear engine.
package grce_pkg;

   localparam int MAP_WIDTH  = 512;
   localparam int MAP_HEIGHT = 512;

   localparam int COORD_W = 9;
   localparam int COST_W  = 8;
   localparam int COUNT_W = 9;
   localparam int ERR_W   = COORD_W + 3;

   localparam int CELLS  = MAP_WIDTH * MAP_HEIGHT;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int MW_W   = $clog2(MAP_WIDTH) + 1;
   localparam int LIN_W  = ADDR_W + COORD_W + MW_W;

   localparam logic [ADDR_W-1:0] SWEEP_LAST      = ADDR_W'(CELLS - 1);
   localparam logic [COST_W-1:0] OUT_OF_MAP_COST = COST_W'(255);
   localparam logic [COST_W-1:0] FREE_COST       = COST_W'(0);

   typedef enum logic [1:0] {
      CMD_RAY       = 2'd0,
      CMD_WRITE     = 2'd1,
      CMD_READ      = 2'd2,
      CMD_CLEAR_ALL = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [COORD_W-1:0] x0;
      logic [COORD_W-1:0] y0;
      logic [COORD_W-1:0] x1;
      logic [COORD_W-1:0] y1;
   } walk_load_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               at_end;
      logic               next_is_end;
   } walk_stat_type;

   function automatic logic in_map(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      return (int'(x) < MAP_WIDTH) && (int'(y) < MAP_HEIGHT);
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(logic [COORD_W-1:0] x,
                                                   logic [COORD_W-1:0] y);
      logic [LIN_W-1:0] lin;
      lin = LIN_W'(y) * LIN_W'(MAP_WIDTH) + LIN_W'(x);
      return lin[ADDR_W-1:0];
   endfunction

endpackage

@@ rtl/grce_if.sv @@
// Valid/ready channel interfaces for command words and result words.
interface grce_req_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      command;
   logic [grce_pkg::COORD_W-1:0]    start_x;
   logic [grce_pkg::COORD_W-1:0]    start_y;
   logic [grce_pkg::COORD_W-1:0]    end_x;
   logic [grce_pkg::COORD_W-1:0]    end_y;
   logic                            end_blocked;
   logic [grce_pkg::COST_W-1:0]     write_cost;

   modport source (output valid, command, start_x, start_y, end_x, end_y, end_blocked,
                   write_cost, input ready);
   modport sink   (input valid, command, start_x, start_y, end_x, end_y, end_blocked,
                   write_cost, output ready);
endinterface

interface grce_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [grce_pkg::COST_W-1:0]     cell_cost;
   logic [grce_pkg::COUNT_W-1:0]    cells_cleared;

   modport source (output valid, cell_cost, cells_cleared, input ready);
   modport sink   (input valid, cell_cost, cells_cleared, output ready);
endinterface

@@ rtl/grid_ray_clear_engine_unit.sv @@
// Top level: command sequencer, cost grid memory and result register.
//
// A cost grid of MAP_WIDTH x MAP_HEIGHT 8-bit cells lives in one single-port
// RAM. After reset the block sweeps the whole grid to 0, one cell a cycle,
// and holds req_if.ready low until the sweep ends. On a clear-ray command the
// line stepper advances one cell a cycle and each cleared cell costs one write
// on the RAM port. Clear-all runs the same sweep as after reset. The block is
// ready for the next command in the same cycle that the result word appears.
// One command is in flight at a time; a finished result waits in the output
// register while the next command is accepted, and a command that finishes
// while that register is still full holds until it frees.
module grid_ray_clear_engine_unit (
   input logic       clock,
   input logic       reset,
   grce_req_if.sink  req_if,
   grce_rsp_if.source rsp_if
);
   import grce_pkg::*;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_WALK,
      ST_WRITE,
      ST_READ,
      ST_READ_WAIT,
      ST_CLEAR,
      ST_FINISH
   } state_type;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  sweep_ff, sweep_in;
   cmd_type            cmd_ff, cmd_in;
   logic [COORD_W-1:0] tx_ff, tx_in, ty_ff, ty_in;
   logic [COST_W-1:0]  wcost_ff, wcost_in;
   logic               keep_ff, keep_in;
   logic               pend_ff, pend_in;
   logic [COUNT_W-1:0] clear_cnt_ff, clear_cnt_in;
   logic [COST_W-1:0]  res_cost_ff, res_cost_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COST_W-1:0]  rsp_cost_ff, rsp_cost_in;
   logic [COUNT_W-1:0] rsp_cleared_ff, rsp_cleared_in;

   walk_load_type      walk_load_data;
   walk_stat_type      walk_stat;
   logic               walk_load, walk_step;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_addr;
   logic [COST_W-1:0]  ram_wdata, ram_rdata;
   logic [COORD_W-1:0] coord_x, coord_y;
   logic [ADDR_W-1:0]  coord_addr;
   logic               ray_we, target_in_map;

   grce_walk u_walk (
      .clock     (clock),
      .load      (walk_load),
      .load_data (walk_load_data),
      .step      (walk_step),
      .stat      (walk_stat)
   );

   grce_ram #(
      .WIDTH (COST_W),
      .DEPTH (CELLS)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   assign walk_load_data = '{x0: req_if.start_x, y0: req_if.start_y,
                             x1: req_if.end_x,   y1: req_if.end_y};

   // Ray cell writes come in the cycle after the step that reached the cell.
   assign ray_we        = pend_ff && in_map(walk_stat.x, walk_stat.y);
   assign target_in_map = in_map(tx_ff, ty_ff);

   always_comb begin
      coord_x    = (state_ff == ST_WALK) ? walk_stat.x : tx_ff;
      coord_y    = (state_ff == ST_WALK) ? walk_stat.y : ty_ff;
      coord_addr = cell_addr(coord_x, coord_y);
      ram_we     = 1'b0;
      ram_addr   = coord_addr;
      ram_wdata  = FREE_COST;
      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            ram_we   = 1'b1;
            ram_addr = sweep_ff;
         end
         ST_WALK:  ram_we = ray_we;
         ST_WRITE: begin
            ram_we    = target_in_map;
            ram_wdata = wcost_ff;
         end
         default: ram_we = 1'b0;
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      sweep_in       = sweep_ff;
      cmd_in         = cmd_ff;
      tx_in          = tx_ff;
      ty_in          = ty_ff;
      wcost_in       = wcost_ff;
      keep_in        = keep_ff;
      pend_in        = 1'b0;
      clear_cnt_in   = clear_cnt_ff;
      res_cost_in    = res_cost_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_cost_in    = rsp_cost_ff;
      rsp_cleared_in = rsp_cleared_ff;
      walk_load      = 1'b0;
      walk_step      = 1'b0;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_INIT: begin
            sweep_in = sweep_ff + ADDR_W'(1);
            if (sweep_ff == SWEEP_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_if.valid) begin
               cmd_in       = cmd_type'(req_if.command);
               tx_in        = req_if.end_x;
               ty_in        = req_if.end_y;
               wcost_in     = req_if.write_cost;
               keep_in      = req_if.end_blocked;
               clear_cnt_in = '0;
               res_cost_in  = '0;
               sweep_in     = '0;
               unique case (cmd_type'(req_if.command))
                  CMD_RAY: begin
                     walk_load = 1'b1;
                     state_in  = ST_WALK;
                  end
                  CMD_WRITE:     state_in = ST_WRITE;
                  CMD_READ:      state_in = ST_READ;
                  CMD_CLEAR_ALL: state_in = ST_CLEAR;
               endcase
            end
         end
         ST_WALK: begin
            if (ray_we) begin
               clear_cnt_in = clear_cnt_ff + COUNT_W'(1);
            end
            if (walk_stat.at_end) begin
               state_in = ST_FINISH;
            end else begin
               walk_step = 1'b1;
               // drop the end cell when it holds the obstacle
               pend_in   = !(keep_ff && walk_stat.next_is_end);
            end
         end
         ST_WRITE:     state_in = ST_FINISH;
         ST_READ:      state_in = ST_READ_WAIT;
         ST_READ_WAIT: begin
            res_cost_in = target_in_map ? ram_rdata : OUT_OF_MAP_COST;
            state_in    = ST_FINISH;
         end
         ST_CLEAR: begin
            sweep_in = sweep_ff + ADDR_W'(1);
            if (sweep_ff == SWEEP_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_cost_in    = res_cost_ff;
               rsp_cleared_in = clear_cnt_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      tx_ff          <= tx_in;
      ty_ff          <= ty_in;
      wcost_ff       <= wcost_in;
      keep_ff        <= keep_in;
      clear_cnt_ff   <= clear_cnt_in;
      res_cost_ff    <= res_cost_in;
      rsp_cost_ff    <= rsp_cost_in;
      rsp_cleared_ff <= rsp_cleared_in;
   end

   assign req_if.ready         = (state_ff == ST_IDLE);
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.cell_cost     = rsp_cost_ff;
   assign rsp_if.cells_cleared = rsp_cleared_ff;

   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT || state_ff == ST_CLEAR) |-> !req_if.ready)
      else $error("command accepted during grid sweep");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && (!rsp_valid_ff || rsp_if.ready))
         |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished command did not reach the output register");

   a_nonray_zero_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && cmd_ff != CMD_RAY) |-> (clear_cnt_ff == '0))
      else $error("cleared count nonzero for a non-ray command");

   a_pend_after_walk: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == ST_WALK && $past(state_ff) == ST_WALK))
      else $error("ray cell write pending outside the walk");

   a_boot_sweep_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT && sweep_ff == SWEEP_LAST) |=> (state_ff == ST_IDLE))
      else $error("reset sweep did not end at the last cell");

endmodule

@@ rtl/grce_ram.sv @@
// Generic single-port RAM with registered read.
module grce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

@@ rtl/grce_walk.sv @@
// Bresenham line stepper: holds the current cell and error term, one cell a step.
module grce_walk (
   input  logic                    clock,
   input  logic                    load,
   input  grce_pkg::walk_load_type load_data,
   input  logic                    step,
   output grce_pkg::walk_stat_type stat
);
   import grce_pkg::*;

   localparam int E2_W = ERR_W + 1;

   logic [COORD_W-1:0]      x_ff, y_ff, x1_ff, y1_ff, dx_ff, dy_ff;
   logic                    sx_neg_ff, sy_neg_ff;
   logic signed [ERR_W-1:0] err_ff;

   logic [COORD_W-1:0]      dx_ld, dy_ld;
   logic signed [ERR_W-1:0] err_ld;
   logic signed [E2_W-1:0]  e2, dx_e, dy_e;
   logic                    mv_x, mv_y;
   logic signed [ERR_W-1:0] err_in;
   logic [COORD_W-1:0]      x_in, y_in;

   always_comb begin
      dx_ld = (load_data.x1 >= load_data.x0) ? load_data.x1 - load_data.x0
                                             : load_data.x0 - load_data.x1;
      dy_ld = (load_data.y1 >= load_data.y0) ? load_data.y1 - load_data.y0
                                             : load_data.y0 - load_data.y1;
      err_ld = $signed(ERR_W'(dx_ld)) - $signed(ERR_W'(dy_ld));

      e2   = {err_ff, 1'b0};
      dx_e = $signed(E2_W'(dx_ff));
      dy_e = $signed(E2_W'(dy_ff));
      mv_x = e2 > -dy_e;
      mv_y = e2 < dx_e;

      err_in = err_ff - (mv_x ? $signed(ERR_W'(dy_ff)) : '0)
                      + (mv_y ? $signed(ERR_W'(dx_ff)) : '0);
      x_in = x_ff;
      if (mv_x) begin
         x_in = sx_neg_ff ? x_ff - COORD_W'(1) : x_ff + COORD_W'(1);
      end
      y_in = y_ff;
      if (mv_y) begin
         y_in = sy_neg_ff ? y_ff - COORD_W'(1) : y_ff + COORD_W'(1);
      end

      stat.x           = x_ff;
      stat.y           = y_ff;
      stat.at_end      = (x_ff == x1_ff) && (y_ff == y1_ff);
      stat.next_is_end = (x_in == x1_ff) && (y_in == y1_ff);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff      <= load_data.x0;
         y_ff      <= load_data.y0;
         x1_ff     <= load_data.x1;
         y1_ff     <= load_data.y1;
         dx_ff     <= dx_ld;
         dy_ff     <= dy_ld;
         sx_neg_ff <= !(load_data.x0 < load_data.x1);
         sy_neg_ff <= !(load_data.y0 < load_data.y1);
         err_ff    <= err_ld;
      end else if (step) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         err_ff <= err_in;
      end
   end

endmodule
